FILE: src/assert_macros.svh
// assertion helpers for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpa assertion failed");

// next-cycle implication
`define BPA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpa assertion failed");

`endif

FILE: src/bpa_pkg.sv
package bpa_pkg;

   localparam int DATA_W          = 40;
   localparam int SHIFT_W         = 5;
   localparam int TREE_LEVELS_DEF = 6;
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = 5'd12;
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX = 5'd24;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOSPACE = 2'd1,
      STATUS_UNSPLIT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      NODE_FREE  = 2'd0,
      NODE_ALLOC = 2'd1,
      NODE_SPLIT = 2'd2,
      NODE_FULL  = 2'd3
   } node_state_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [DATA_W-1:0] request_size;
      logic [DATA_W-1:0] free_offset;
      logic [DATA_W-1:0] free_size;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [DATA_W-1:0] block_offset;
      logic [DATA_W-1:0] block_size;
   } rsp_type;

endpackage

FILE: src/bpa_node_mem.sv
module bpa_node_mem #(
   parameter int ADDR_W = bpa_pkg::TREE_LEVELS_DEF + 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_W-1:0]       wr_addr,
   input  bpa_pkg::node_state_type wr_data,
   input  logic [ADDR_W-1:0]       rd_addr,
   output bpa_pkg::node_state_type rd_data
);
   import bpa_pkg::*;

   node_state_type mem [2**ADDR_W];
   node_state_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: src/bpa_walker.sv
module bpa_walker #(
   parameter int TREE_LEVELS = bpa_pkg::TREE_LEVELS_DEF,
   parameter int ADDR_W      = TREE_LEVELS + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bpa_pkg::SHIFT_W-1:0] page_shift,
   input  logic                        start,
   input  bpa_pkg::req_type            req,
   output logic                        idle,
   output logic                        done,
   input  logic                        slot_free,
   output bpa_pkg::rsp_type            result,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output bpa_pkg::node_state_type     wr_data,
   output logic [ADDR_W-1:0]           rd_addr,
   input  bpa_pkg::node_state_type     rd_data
);
   import bpa_pkg::*;

   localparam int DEPTH_W = $clog2(TREE_LEVELS + 1);
   localparam logic [DEPTH_W-1:0] LEAF_DEPTH = DEPTH_W'(TREE_LEVELS);
   localparam logic [ADDR_W-1:0]  ROOT       = ADDR_W'(1);

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_RD    = 9'b000000100,
      S_EVAL  = 9'b000001000,
      S_FAIL  = 9'b000010000,
      S_UPL   = 9'b000100000,
      S_UPR   = 9'b001000000,
      S_UPW   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    node_ff, node_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [DATA_W-1:0]    off_ff, off_in;
   logic [DATA_W-1:0]    size_ff, size_in;
   req_type              req_ff, req_in;
   rsp_type              res_ff, res_in;
   node_state_type       left_ff, left_in;

   logic [SHIFT_W-1:0]   eff_shift;
   logic [DATA_W-1:0]    pool;
   logic [DATA_W-1:0]    half;
   logic [DATA_W:0]      mid;
   logic                 is_full, leaf, match, both_full, both_free;

   always_comb begin
      eff_shift = (page_shift > PAGE_SHIFT_MAX) ? PAGE_SHIFT_MAX : page_shift;
      pool      = DATA_W'(1) << (TREE_LEVELS + int'(eff_shift));
      half      = size_ff >> 1;
      mid       = {1'b0, off_ff} + {1'b0, half};
      is_full   = (rd_data == NODE_ALLOC) || (rd_data == NODE_FULL);
      leaf      = (depth_ff == LEAF_DEPTH);
      match     = (req_ff.free_size == size_ff) && (req_ff.free_offset == off_ff);
      both_full = ((left_ff == NODE_ALLOC) || (left_ff == NODE_FULL))
                  && ((rd_data == NODE_ALLOC) || (rd_data == NODE_FULL));
      both_free = (left_ff == NODE_FREE) && (rd_data == NODE_FREE);
   end

   always_comb begin
      unique case (state_ff)
         S_UPL:   rd_addr = {node_ff[ADDR_W-2:0], 1'b0};
         S_UPR:   rd_addr = {node_ff[ADDR_W-2:0], 1'b1};
         default: rd_addr = node_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      depth_in = depth_ff;
      off_in   = off_ff;
      size_in  = size_ff;
      req_in   = req_ff;
      res_in   = res_ff;
      left_in  = left_ff;
      wr_en    = 1'b0;
      wr_addr  = node_ff;
      wr_data  = NODE_FREE;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            node_in = node_ff + ADDR_W'(1);
            if (&node_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               res_in   = '{status: STATUS_OK, block_offset: '0, block_size: '0};
               node_in  = ROOT;
               depth_in = '0;
               off_in   = '0;
               size_in  = pool;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (req_ff.cmd == CMD_ALLOC) begin
               priority if (is_full || (req_ff.request_size > size_ff)) begin
                  state_in = S_FAIL;
               end else if (leaf || (req_ff.request_size > half)) begin
                  if (rd_data != NODE_FREE) begin
                     state_in = S_FAIL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = NODE_ALLOC;
                     res_in.block_offset = off_ff;
                     res_in.block_size   = size_ff;
                     node_in  = node_ff >> 1;
                     state_in = (node_ff == ROOT) ? S_DONE : S_UPL;
                  end
               end else begin
                  // split a free node on the way down
                  wr_en    = (rd_data == NODE_FREE);
                  wr_data  = NODE_SPLIT;
                  node_in  = {node_ff[ADDR_W-2:0], 1'b0};
                  depth_in = depth_ff + DEPTH_W'(1);
                  size_in  = half;
                  state_in = S_RD;
               end
            end else begin
               priority if (match) begin
                  wr_en   = (rd_data == NODE_ALLOC) || (rd_data == NODE_FULL);
                  wr_data = (rd_data == NODE_ALLOC) ? NODE_FREE : NODE_SPLIT;
                  node_in  = node_ff >> 1;
                  state_in = (node_ff == ROOT) ? S_DONE : S_UPL;
               end else if ((rd_data == NODE_FREE) || (rd_data == NODE_ALLOC) || leaf) begin
                  res_in.status = STATUS_UNSPLIT;
                  node_in  = node_ff >> 1;
                  state_in = (node_ff == ROOT) ? S_DONE : S_UPL;
               end else begin
                  if ({1'b0, req_ff.free_offset} >= mid) begin
                     node_in = {node_ff[ADDR_W-2:0], 1'b1};
                     off_in  = mid[DATA_W-1:0];
                  end else begin
                     node_in = {node_ff[ADDR_W-2:0], 1'b0};
                  end
                  depth_in = depth_ff + DEPTH_W'(1);
                  size_in  = half;
                  state_in = S_RD;
               end
            end
         end
         S_FAIL: begin
            // backtrack: right sibling next, else parent fails too
            priority if (node_ff == ROOT) begin
               res_in.status = STATUS_NOSPACE;
               state_in      = S_DONE;
            end else if (!node_ff[0]) begin
               node_in  = node_ff + ADDR_W'(1);
               off_in   = off_ff + size_ff;
               state_in = S_RD;
            end else begin
               node_in  = node_ff >> 1;
               off_in   = off_ff - size_ff;
               size_in  = size_ff << 1;
               depth_in = depth_ff - DEPTH_W'(1);
            end
         end
         S_UPL: begin
            state_in = S_UPR;
         end
         S_UPR: begin
            left_in  = rd_data;
            state_in = S_UPW;
         end
         S_UPW: begin
            wr_en = 1'b1;
            if (req_ff.cmd == CMD_ALLOC) begin
               wr_data = both_full ? NODE_FULL : NODE_SPLIT;
            end else begin
               wr_data = both_free ? NODE_FREE : NODE_SPLIT;
            end
            node_in  = node_ff >> 1;
            state_in = (node_ff == ROOT) ? S_DONE : S_UPL;
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         node_ff  <= '0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
      end
      depth_ff <= depth_in;
      off_ff   <= off_in;
      size_ff  <= size_in;
      req_ff   <= req_in;
      res_ff   <= res_in;
      left_ff  <= left_in;
   end

   assign idle   = (state_ff == S_IDLE);
   assign done   = (state_ff == S_DONE);
   assign result = res_ff;
endmodule

FILE: src/buddy_page_allocator.sv
// Binary buddy allocator over 2^TREE_LEVELS pages of 2^page_shift bytes each
// (page_shift above 24 acts as 24), one request at a time. The node states
// sit in a single-port-write memory with registered reads. After reset a
// clearing pass writes every one of the 2^(TREE_LEVELS+1) entries before
// req_ready first rises. An allocate reads and evaluates each node visited in
// the depth-first search (each backtrack step up adds a pass through the fail
// state), then refreshes the full marks level by level on the way back and
// hands the result over; a search that backtracks through a fragmented tree
// takes longer than one on a fresh tree. A free reads and evaluates one node
// per level going down, refreshes the marks per level going up and then hands
// the result over. req_ready rises again as the result enters the output
// register, so the next request is taken while it is still pending.
module buddy_page_allocator #(
   parameter int TREE_LEVELS = bpa_pkg::TREE_LEVELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  bpa_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bpa_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [bpa_pkg::SHIFT_W-1:0] csr_wdata
);
   import bpa_pkg::*;
`include "assert_macros.svh"

   // heap-ordered node store, root at index 1
   localparam int ADDR_W = TREE_LEVELS + 1;

   logic [SHIFT_W-1:0] page_shift_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               walk_idle, walk_done, slot_free;
   rsp_type            walk_result;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   node_state_type     wr_data, rd_data;

   // page size register; the user must write it only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= PAGE_SHIFT_RST;
      end else if (csr_we) begin
         page_shift_ff <= csr_wdata;
      end
   end

   bpa_node_mem #(.ADDR_W(ADDR_W)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bpa_walker #(.TREE_LEVELS(TREE_LEVELS), .ADDR_W(ADDR_W)) u_walker (
      .clock      (clock),
      .reset      (reset),
      .page_shift (page_shift_ff),
      .start      (req_valid),
      .req        (req_data),
      .idle       (walk_idle),
      .done       (walk_done),
      .slot_free  (slot_free),
      .result     (walk_result),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // output register: load when the held beat is gone or leaving now
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (walk_done && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = walk_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = walk_idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // one request in flight: accepting a beat makes the walker busy
   `BPA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // failed results carry no block (free results with status OK carry none either)
   `BPA_ASSERT_NOW(a_no_block_on_error, clock, reset, rsp_valid && (rsp_data.status != STATUS_OK), (rsp_data.block_size == '0) && (rsp_data.block_offset == '0))
   // a granted block is aligned to its own size
   `BPA_ASSERT_NOW(a_grant_aligned, clock, reset, rsp_valid && (rsp_data.block_size != '0), (rsp_data.block_offset & (rsp_data.block_size - DATA_W'(1))) == '0)
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bpa_pkg::*;

   localparam int LEVELS   = TREE_LEVELS_DEF;
   localparam int NODES    = 1 << (LEVELS + 1);
   localparam int N_RANDOM = 1425;
   localparam longint CYCLE_LIMIT = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [SHIFT_W-1:0] csr_wdata = '0;

   buddy_page_allocator #(.TREE_LEVELS(LEVELS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the allocator tree and the page shift register
   node_state_type tree[NODES];
   logic [SHIFT_W-1:0] shadow_shift;
   logic [DATA_W-1:0]  grant_off, grant_len;

   rsp_type pending_rsp[$];
   int      errors = 0;
   longint  cycles = 0;

   // idle rates in percent, and the long stall request for the receiver
   int  send_idle = 15, recv_idle = 53;
   int  hold_cycles = 0;

   // blocks handed out so far, used to build well-formed frees
   logic [DATA_W-1:0] live_off[$], live_len[$];

   function automatic bit taken(node_state_type s);
      return s == NODE_ALLOC || s == NODE_FULL;
   endfunction

   function automatic logic [DATA_W-1:0] pool_bytes();
      int sh;
      sh = (shadow_shift > PAGE_SHIFT_MAX) ? PAGE_SHIFT_MAX : shadow_shift;
      return 40'd1 << (LEVELS + sh);
   endfunction

   function automatic bit place_block(int n, int depth, logic [DATA_W-1:0] off,
                                      logic [DATA_W-1:0] len, logic [DATA_W-1:0] want);
      node_state_type s;
      logic [DATA_W-1:0] half;
      s = tree[n];
      half = len >> 1;
      if (taken(s) || want > len) return 0;
      if (depth >= LEVELS || want > half) begin
         if (s != NODE_FREE) return 0;
         tree[n] = NODE_ALLOC;
         grant_off = off;
         grant_len = len;
         return 1;
      end
      if (s == NODE_FREE) tree[n] = NODE_SPLIT;
      if (place_block(2*n, depth+1, off, half, want) ||
          place_block(2*n+1, depth+1, off+half, half, want)) begin
         tree[n] = (taken(tree[2*n]) && taken(tree[2*n+1])) ? NODE_FULL : NODE_SPLIT;
         return 1;
      end
      return 0;
   endfunction

   function automatic status_type return_block(int n, int depth,
         logic [DATA_W-1:0] off, logic [DATA_W-1:0] len,
         logic [DATA_W-1:0] foff, logic [DATA_W-1:0] flen);
      node_state_type s;
      logic [DATA_W-1:0] half;
      status_type st;
      s = tree[n];
      half = len >> 1;
      if (flen == len && foff == off) begin
         if (s == NODE_ALLOC) tree[n] = NODE_FREE;
         else if (s == NODE_FULL) tree[n] = NODE_SPLIT;
         return STATUS_OK;
      end
      if (s == NODE_FREE || s == NODE_ALLOC || depth >= LEVELS) return STATUS_UNSPLIT;
      // full-width sum so an offset near the top does not wrap
      if ({1'b0, foff} >= {1'b0, off} + {1'b0, half})
         st = return_block(2*n+1, depth+1, off+half, half, foff, flen);
      else
         st = return_block(2*n, depth+1, off, half, foff, flen);
      tree[n] = (tree[2*n] == NODE_FREE && tree[2*n+1] == NODE_FREE) ?
                NODE_FREE : NODE_SPLIT;
      return st;
   endfunction

   function automatic rsp_type predict_allocator(req_type r);
      rsp_type o;
      logic [DATA_W-1:0] pool;
      pool = pool_bytes();
      o = '0;
      grant_off = '0;
      grant_len = '0;
      if (r.cmd == CMD_ALLOC) begin
         if (r.request_size > pool || !place_block(1, 0, '0, pool, r.request_size))
            o.status = STATUS_NOSPACE;
         else begin
            o.status = STATUS_OK;
            o.block_offset = grant_off;
            o.block_size = grant_len;
         end
      end else begin
         o.status = return_block(1, 0, '0, pool, r.free_offset, r.free_size);
      end
      return o;
   endfunction

   // cycle counter doubles as watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random backpressure plus an optional long hold
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_left = hold_cycles;
            hold_cycles = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // check each beat on the result side
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected beat %p", $time, rsp_data);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               $display("%0t: status expected %0d got %0d", $time, want.status,
                        rsp_data.status);
            if (rsp_data.block_offset !== want.block_offset)
               $display("%0t: block_offset expected %h got %h", $time,
                        want.block_offset, rsp_data.block_offset);
            if (rsp_data.block_size !== want.block_size)
               $display("%0t: block_size expected %h got %h", $time,
                        want.block_size, rsp_data.block_size);
            if (rsp_data !== want) errors++;
         end
      end
   end

   // send one request beat; the typed-in result is checked only with use_fixed
   task automatic send_beat(req_type r, rsp_type fixed, bit use_fixed);
      rsp_type p;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_allocator(r);
      if (p.status == STATUS_OK && r.cmd == CMD_ALLOC) begin
         live_off.push_back(p.block_offset);
         live_len.push_back(p.block_size);
      end
      if (use_fixed && p !== fixed) begin
         $display("%0t: table row expected %p predictor %p", $time, fixed, p);
         errors++;
      end
      pending_rsp.push_back(use_fixed ? fixed : p);
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_shift(logic [SHIFT_W-1:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_shift = v;
      live_off.delete();
      live_len.delete();
   endtask

   function automatic req_type mk(cmd_type c, logic [DATA_W-1:0] a,
                                  logic [DATA_W-1:0] b, logic [DATA_W-1:0] d);
      req_type r;
      r.cmd = c;
      r.request_size = a;
      r.free_offset = b;
      r.free_size = d;
      return r;
   endfunction

   function automatic rsp_type mr(status_type s, logic [DATA_W-1:0] o,
                                  logic [DATA_W-1:0] l);
      rsp_type x;
      x.status = s;
      x.block_offset = o;
      x.block_size = l;
      return x;
   endfunction

   function automatic logic [DATA_W-1:0] rnd40();
      return {$urandom(), $urandom()};
   endfunction

   // one random beat: mostly well-formed traffic with a bit of noise
   function automatic req_type random_beat();
      logic [DATA_W-1:0] pool;
      int k, sel;
      pool = pool_bytes();
      sel = $urandom_range(99);
      if (sel < 45) begin
         k = $urandom_range(LEVELS);
         return mk(CMD_ALLOC, (pool >> k) - ($urandom_range(1) ? '0 :
                   $urandom_range(3)), rnd40(), rnd40());
      end else if (sel < 85 && live_off.size() > 0) begin
         k = $urandom_range(live_off.size() - 1);
         mk_free: begin
            req_type r;
            r = mk(CMD_FREE, rnd40(), live_off[k], live_len[k]);
            live_off.delete(k);
            live_len.delete(k);
            return r;
         end
      end else if (sel < 92) begin
         k = $urandom_range(LEVELS);
         return mk(CMD_FREE, rnd40(),
                   (pool >> k) * $urandom_range((1 << k) - 1), pool >> k);
      end
      return mk(cmd_type'($urandom_range(1)), rnd40() >> $urandom_range(39),
                rnd40() >> $urandom_range(39), rnd40() >> $urandom_range(39));
   endfunction

   // directed table, page shift 12: pool is 256 KiB, page 4 KiB
   typedef struct {
      req_type r;
      rsp_type e;
      bit      fixed;
   } row_type;

   row_type plan[$];

   initial begin
      logic [SHIFT_W-1:0] shifts[5];
      shifts = '{5'd0, 5'd31, 5'd24, 5'd3, 5'd12};
      for (int i = 1; i < NODES; i++) tree[i] = NODE_FREE;
      shadow_shift = PAGE_SHIFT_RST;

      // whole pool, a request while it is taken, freeing it back, then oversize
      plan.push_back('{mk(CMD_ALLOC, 40'h40000, 0, 0), mr(STATUS_OK, 0, 40'h40000), 1});
      plan.push_back('{mk(CMD_ALLOC, 40'h0, 0, 0), mr(STATUS_NOSPACE, 0, 0), 1});
      plan.push_back('{mk(CMD_FREE, 0, 0, 40'h40000), mr(STATUS_OK, 0, 0), 1});
      plan.push_back('{mk(CMD_ALLOC, 40'h40001, 0, 0), mr(STATUS_NOSPACE, 0, 0), 1});
      plan.push_back('{mk(CMD_ALLOC, '1, '1, '1), mr(STATUS_NOSPACE, 0, 0), 1});
      // zero request takes one page, freeing unsplit nodes errors
      plan.push_back('{mk(CMD_ALLOC, 0, 0, 0), mr(STATUS_OK, 0, 40'h1000), 1});
      plan.push_back('{mk(CMD_ALLOC, 1, 0, 0), mr(STATUS_OK, 40'h1000, 40'h1000), 1});
      plan.push_back('{mk(CMD_ALLOC, 40'h1001, 0, 0), mr(STATUS_OK, 40'h2000, 40'h2000), 1});
      plan.push_back('{mk(CMD_FREE, 0, 40'h1000, 40'h800), mr(STATUS_UNSPLIT, 0, 0), 1});
      plan.push_back('{mk(CMD_FREE, 0, '1, '1), mr(STATUS_UNSPLIT, 0, 0), 0});
      plan.push_back('{mk(CMD_FREE, 0, 40'h20000, 40'h1000), mr(STATUS_UNSPLIT, 0, 0), 0});
      // split node of matching size: only its full mark goes
      plan.push_back('{mk(CMD_FREE, 0, 0, 40'h2000), mr(STATUS_OK, 0, 0), 0});
      plan.push_back('{mk(CMD_FREE, 0, 0, 40'h1000), mr(STATUS_OK, 0, 0), 0});
      plan.push_back('{mk(CMD_FREE, 0, 40'h1000, 40'h1000), mr(STATUS_OK, 0, 0), 0});
      plan.push_back('{mk(CMD_FREE, 0, 40'h2000, 40'h2000), mr(STATUS_OK, 0, 0), 0});
      plan.push_back('{mk(CMD_FREE, 0, 0, 40'h40000), mr(STATUS_OK, 0, 0), 0});
      for (int i = 0; i < 6; i++)
         plan.push_back('{mk(CMD_ALLOC, 40'h1000 << i, 0, 0), mr(STATUS_OK, 0, 0), 0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_beat(plan[i].r, plan[i].e, plan[i].fixed);

      // random phases over page shift settings, idle mix changes on the way
      foreach (shifts[s]) begin
         write_shift(shifts[s]);
         for (int i = 0; i < N_RANDOM / 5; i++) begin
            if (i == N_RANDOM / 10) begin
               send_idle = (s < 2) ? 15 : (s < 4) ? 53 : 0;
               recv_idle = (s < 2) ? 53 : (s < 4) ? 15 : 0;
            end
            if (s == 1 && i == 40) hold_cycles = 800;
            if (s == 2 && i == 60) wait_drained();
            send_beat(random_beat(), '0, 0);
         end
      end

      wait_drained();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
